>>> sv/assert_macros.svh
// Assertion helpers; every use sits in a module with clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/bfa_pkg.sv
package bfa_pkg;

	localparam int NUM_BLOCKS = 32;
	localparam int SIZE_BITS  = 16;
	localparam int IDX_BITS   = $clog2(NUM_BLOCKS);
	localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

	typedef enum logic {
		KIND_LOAD    = 1'b0,
		KIND_REQUEST = 1'b1
	} kind_t;

	typedef struct packed {
		logic                 kind;
		logic [SIZE_BITS-1:0] size_value;
	} item_t;

	typedef struct packed {
		logic                 allocated;
		logic [IDX_BITS-1:0]  block_index;
		logic [SIZE_BITS-1:0] block_size;
		logic [SIZE_BITS-1:0] leftover;
	} result_t;

	// One table entry: used mark and block size.
	typedef struct packed {
		logic                 used;
		logic [SIZE_BITS-1:0] size;
	} entry_t;

	// Running best candidate of a scan.
	typedef struct packed {
		logic                 found;
		logic [IDX_BITS-1:0]  idx;
		logic [SIZE_BITS-1:0] size;
	} best_t;

endpackage

>>> sv/best_fit_block_allocator.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+-----------------------------------
// item     | item_valid / item_ready    | bfa_pkg::item_t  (kind, size_value)
// result   | result_valid / result_ready| bfa_pkg::result_t (one per request)
//
// A load leaves the block in idle, so item_ready stays high. A request keeps
// item_ready low through its scan: a read of each loaded block, the last compare,
// leaving the scan, then registering the result and marking the block.
// Reset clears the block count and control state; loaded entries are the only
// ones ever read, so the table needs no clearing pass.
// A waiting result still lets loads in; the next request then stalls in ST_DONE.
`include "assert_macros.svh"

module best_fit_block_allocator (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  bfa_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output bfa_pkg::result_t  result
);
	import bfa_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [CNT_BITS-1:0]  count_q;     // blocks loaded
	logic [CNT_BITS-1:0]  issue_q;     // next table address to read
	logic [SIZE_BITS-1:0] req_size_q;
	logic                 cmp_vld_s1;  // read data is valid this cycle
	logic [IDX_BITS-1:0]  cmp_idx_s1;
	logic                 result_valid_q;
	result_t              result_q;

	logic                 accept;
	logic                 do_load;
	logic                 do_issue;
	logic                 out_free;
	logic                 finish;
	logic                 wr_en;
	logic [IDX_BITS-1:0]  wr_addr;
	entry_t               wr_data;
	entry_t               rd_data;
	best_t                best;

	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign do_load    = accept && (item.kind == KIND_LOAD) &&
	                    (count_q < CNT_BITS'(NUM_BLOCKS));
	assign do_issue   = (state_q == ST_SCAN) && (issue_q < count_q);
	assign out_free   = !result_valid_q || result_ready;
	assign finish     = (state_q == ST_DONE) && out_free;

	// Single write port: loads in idle, used-mark write-back at the end of a scan.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[IDX_BITS-1:0];
		wr_data = '{used: 1'b0, size: item.size_value};
		if (do_load) begin
			wr_en = 1'b1;
		end else if (finish && best.found) begin
			wr_en   = 1'b1;
			wr_addr = best.idx;
			wr_data = '{used: 1'b1, size: best.size};
		end
	end

	bfa_table u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (do_issue),
		.rd_addr (issue_q[IDX_BITS-1:0]),
		.rd_data (rd_data)
	);

	bfa_best u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (accept),
		.cand_vld (cmp_vld_s1),
		.cand_idx (cmp_idx_s1),
		.cand     (rd_data),
		.req_size (req_size_q),
		.best     (best)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			issue_q        <= '0;
			cmp_vld_s1     <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			cmp_vld_s1 <= do_issue;
			if (do_load) begin
				count_q <= count_q + 1'b1;
			end
			if (finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (item.kind == KIND_REQUEST)) begin
						issue_q <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (do_issue) begin
						issue_q <= issue_q + 1'b1;
					end else if (!cmp_vld_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_size_q <= item.size_value;
		end
		cmp_idx_s1 <= issue_q[IDX_BITS-1:0];
		if (finish) begin
			if (best.found) begin
				result_q.allocated   <= 1'b1;
				result_q.block_index <= best.idx;
				result_q.block_size  <= best.size;
				result_q.leftover    <= best.size - req_size_q;
			end else begin
				result_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_ALWAYS(a_count_bound, count_q <= CNT_BITS'(NUM_BLOCKS), "block count beyond table")
	`ASSERT_IMPLY(a_scan_bound, state_q == ST_SCAN, issue_q <= count_q, "scan past loaded blocks")
	`ASSERT_IMPLY(a_no_write_in_scan, state_q == ST_SCAN, !wr_en, "table written in scan")
	`ASSERT_IMPLY(a_fit_leftover, result_valid && result.allocated, result.leftover <= result.block_size, "bad leftover")
	`ASSERT_IMPLY(a_miss_zero, result_valid && !result.allocated, result.block_size == '0 && result.leftover == '0 && result.block_index == '0, "miss not cleared")

endmodule

>>> sv/bfa_table.sv
module bfa_table (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [bfa_pkg::IDX_BITS-1:0]  wr_addr,
	input  bfa_pkg::entry_t               wr_data,
	input  logic                          rd_en,
	input  logic [bfa_pkg::IDX_BITS-1:0]  rd_addr,
	output bfa_pkg::entry_t               rd_data
);
	import bfa_pkg::*;

	entry_t mem [NUM_BLOCKS];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> sv/bfa_best.sv
module bfa_best (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          cand_vld,
	input  logic [bfa_pkg::IDX_BITS-1:0]  cand_idx,
	input  bfa_pkg::entry_t               cand,
	input  logic [bfa_pkg::SIZE_BITS-1:0] req_size,
	output bfa_pkg::best_t                best
);
	import bfa_pkg::*;

	best_t best_q;
	logic  fits;
	logic  better;

	// Strict less-than keeps the lowest index on a tie.
	assign fits   = !cand.used && (cand.size >= req_size);
	assign better = !best_q.found || (cand.size < best_q.size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (clr) begin
			best_q <= '0;
		end else if (cand_vld && fits && better) begin
			best_q.found <= 1'b1;
			best_q.idx   <= cand_idx;
			best_q.size  <= cand.size;
		end
	end

	assign best = best_q;

endmodule

>>> dv/tb_best_fit_block_allocator.sv
`timescale 1ns / 1ps

module tb_best_fit_block_allocator;
	import bfa_pkg::*;

	// One line of the directed plan. Where 'typed' is set, the expected grant is
	// written out by hand and replaces the predictor's answer for that request.
	typedef struct {
		item_t   req;
		bit      typed;
		result_t want;
	} step_row_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	best_fit_block_allocator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// Shadow of the allocator: block sizes, used marks and fill level.
	logic [SIZE_BITS-1:0] tbl_size [NUM_BLOCKS];
	bit                   tbl_used [NUM_BLOCKS];
	int                   tbl_count = 0;

	// Grants still owed by the block, oldest first.
	result_t grant_queue [$];

	int n_errors     = 0;
	int n_reported   = 0;
	int accepted_cnt = 0;
	int cycle_cnt    = 0;
	bit hold_off     = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Best-fit choice on the shadow table. Loads append (or are dropped when the
	// table is full) and give nothing back; a request always gives one grant.
	function automatic bit best_fit_pick(input item_t x, output result_t r);
		int best;
		bit found;
		r     = '0;
		best  = 0;
		found = 1'b0;
		if (x.kind == KIND_LOAD) begin
			if (tbl_count < NUM_BLOCKS) begin
				tbl_size[tbl_count] = x.size_value;
				tbl_used[tbl_count] = 1'b0;
				tbl_count++;
			end
			return 1'b0;
		end
		// strict '<' keeps the lowest index among blocks of equal size
		for (int i = 0; i < tbl_count; i++) begin
			if (!tbl_used[i] && tbl_size[i] >= x.size_value &&
					(!found || tbl_size[i] < tbl_size[best])) begin
				best  = i;
				found = 1'b1;
			end
		end
		if (found) begin
			tbl_used[best] = 1'b1;
			r.allocated    = 1'b1;
			r.block_index  = IDX_BITS'(best);
			r.block_size   = tbl_size[best];
			r.leftover     = tbl_size[best] - x.size_value;
		end
		return 1'b1;
	endfunction

	// Random back-off on either side; a window in the middle of the run is kept
	// free of gaps so that back-to-back traffic is seen too.
	function automatic bit take_break();
		if (cycle_cnt >= 30000 && cycle_cnt < 40000) begin
			return 1'b0;
		end
		return $urandom_range(99) < 15;
	endfunction

	function automatic step_row_t step_row(input kind_t k, input int sz, input bit typed = 1'b0,
			input bit a = 1'b0, input int idx = 0, input int bs = 0, input int lo = 0);
		step_row_t s;
		s.req.kind              = k;
		s.req.size_value        = SIZE_BITS'(sz);
		s.typed                 = typed;
		s.want.allocated        = a;
		s.want.block_index      = IDX_BITS'(idx);
		s.want.block_size       = SIZE_BITS'(bs);
		s.want.leftover         = SIZE_BITS'(lo);
		return s;
	endfunction

	// Offer one item on the item channel. Called and returning at a falling
	// edge; valid is left high so the next call either keeps it up or drops it,
	// never both in one time step.
	task automatic send_item(input item_t x, input bit typed, input result_t typed_res);
		result_t r;
		bit      has_res;
		while (take_break()) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= x;
		do @(posedge clk); while (!item_ready);
		accepted_cnt++;
		has_res = best_fit_pick(x, r);
		if (has_res) begin
			grant_queue.push_back(typed ? typed_res : r);
		end
		@(negedge clk);
	endtask

	task automatic flag_field(input string f, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			n_errors++;
			if (n_reported < 30) begin
				n_reported++;
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, f, want, got);
			end
		end
	endtask

	// Grant checker: every accepted grant is matched against the oldest one owed.
	always @(posedge clk) begin : grant_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (grant_queue.size() == 0) begin
				n_errors++;
				if (n_reported < 30) begin
					n_reported++;
					$display("%0t ns: grant with none expected, expected nothing, got %p",
						$time, result);
				end
			end else begin
				want = grant_queue.pop_front();
				flag_field("allocated", 32'(want.allocated), 32'(result.allocated));
				flag_field("block_index", 32'(want.block_index), 32'(result.block_index));
				flag_field("block_size", 32'(want.block_size), 32'(result.block_size));
				flag_field("leftover", 32'(want.leftover), 32'(result.leftover));
			end
		end
	end

	// Receiver: random back-pressure, plus one long hold-off below.
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			result_ready <= !hold_off && !take_break();
		end
	end

	// Long hold-off early in the random phase, while the table is still filling:
	// the grant stalls in its output register, loads keep going in, and the next
	// request backs up the item channel.
	initial begin
		wait (accepted_cnt >= 40);
		@(posedge clk);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	initial begin : stimulus
		step_row_t            plan [$];
		item_t                x;
		int                   n_counted;
		int                   mode;
		int                   delta;
		logic [SIZE_BITS-1:0] base;

		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		n_counted  = 0;

		// Directed plan. Indexes in the notes are table slots.
		plan.push_back(step_row(KIND_REQUEST, 5, 1'b1));           // empty table: no fit
		plan.push_back(step_row(KIND_REQUEST, 0, 1'b1));           // zero size, still nothing
		plan.push_back(step_row(KIND_LOAD, 100));                  // slot 0
		plan.push_back(step_row(KIND_LOAD, 0));                    // slot 1
		plan.push_back(step_row(KIND_LOAD, 65535));                // slot 2
		plan.push_back(step_row(KIND_LOAD, 100));                  // slot 3, ties slot 0
		plan.push_back(step_row(KIND_LOAD, 40));                   // slot 4
		plan.push_back(step_row(KIND_REQUEST, 65535, 1'b1, 1'b1, 2, 65535, 0));
		plan.push_back(step_row(KIND_REQUEST, 0, 1'b1, 1'b1, 1, 0, 0));
		plan.push_back(step_row(KIND_REQUEST, 65535, 1'b1));      // largest block gone
		plan.push_back(step_row(KIND_REQUEST, 50));                // tie: lower slot wins
		plan.push_back(step_row(KIND_REQUEST, 50));                // then the other one
		plan.push_back(step_row(KIND_REQUEST, 41, 1'b1));          // only 40 left
		plan.push_back(step_row(KIND_REQUEST, 40));                // exact fit
		plan.push_back(step_row(KIND_LOAD, 1));                    // slot 5
		plan.push_back(step_row(KIND_LOAD, 65534));                // slot 6
		plan.push_back(step_row(KIND_LOAD, 7));                    // slot 7
		plan.push_back(step_row(KIND_LOAD, 7));                    // slot 8
		plan.push_back(step_row(KIND_REQUEST, 7));
		plan.push_back(step_row(KIND_REQUEST, 2));
		plan.push_back(step_row(KIND_REQUEST, 1));
		plan.push_back(step_row(KIND_REQUEST, 30000));
		plan.push_back(step_row(KIND_REQUEST, 0, 1'b1));           // every block used
		plan.push_back(step_row(KIND_LOAD, 'h5555));               // slot 9
		plan.push_back(step_row(KIND_REQUEST, 'h2AAA));

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			send_item(plan[i].req, plan[i].typed, plan[i].want);
		end

		// Random phase. Loads come often until the table is full and then only as
		// noise (dropped, not counted). Request sizes lean towards sizes already
		// loaded so that fits, ties and near misses all turn up.
		while (n_counted < 2000) begin
			if (tbl_count < NUM_BLOCKS) begin
				x.kind = ($urandom_range(99) < 40) ? KIND_LOAD : KIND_REQUEST;
			end else begin
				x.kind = ($urandom_range(99) < 10) ? KIND_LOAD : KIND_REQUEST;
			end
			mode = $urandom_range(99);
			if (x.kind == KIND_LOAD) begin
				if (mode < 50) begin
					x.size_value = SIZE_BITS'($urandom_range(255));
				end else if (mode < 80 || tbl_count == 0) begin
					x.size_value = SIZE_BITS'($urandom);
				end else begin
					x.size_value = tbl_size[$urandom_range(tbl_count - 1)];
				end
			end else begin
				if (mode < 10) begin
					x.size_value = '0;
				end else if (mode < 20) begin
					x.size_value = '1;
				end else if (mode < 40 || tbl_count == 0) begin
					x.size_value = SIZE_BITS'($urandom);
				end else begin
					base         = tbl_size[$urandom_range(tbl_count - 1)];
					delta        = $urandom_range(3);
					x.size_value = (base > delta) ? base - SIZE_BITS'(delta) : '0;
				end
			end
			if (x.kind == KIND_REQUEST || tbl_count < NUM_BLOCKS) begin
				n_counted++;
			end
			send_item(x, 1'b0, '0);
		end
		item_valid <= 1'b0;

		// Drain: wait for every owed grant, then a full scan's worth of cycles to
		// catch anything extra.
		wait (grant_queue.size() == 0);
		repeat (64) @(posedge clk);
		if (n_errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// Watchdog, far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+sv
sv/bfa_pkg.sv
sv/bfa_table.sv
sv/bfa_best.sv
sv/best_fit_block_allocator.sv
dv/tb_best_fit_block_allocator.sv
